// ===== rtl/sdpr_pkg.sv =====
`timescale 1ns / 1ps

package sdpr_pkg;

  localparam int unsigned PADDR_W = 4;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_NORMAL_HDR = 2'd0;
  localparam logic [1:0] REG_LAST_HDR   = 2'd1;
  localparam logic [1:0] REG_CANCEL_HDR = 2'd2;

  localparam logic [7:0] NORMAL_HDR_RESET = 8'd2;
  localparam logic [7:0] LAST_HDR_RESET   = 8'd3;
  localparam logic [7:0] CANCEL_HDR_RESET = 8'd24;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_BYTE  = 1'b1;

  localparam logic NAK_BAD_HEADER = 1'b0;
  localparam logic NAK_OVERRUN    = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HEADER = 3'd1,
    PH_SEQ    = 3'd2,
    PH_LEN    = 3'd3,
    PH_DATA   = 3'd4,
    PH_SLEEP1 = 3'd5,
    PH_SLEEP2 = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NORMAL = 2'd0,
    KIND_LAST   = 2'd1,
    KIND_CANCEL = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    EV_DISPLAY = 3'd0,
    EV_CMD_END = 3'd1,
    EV_ACK     = 3'd2,
    EV_CANCEL  = 3'd3,
    EV_NAK     = 3'd4
  } event_t;

  typedef struct packed {
    logic [7:0] normal_code;
    logic [7:0] last_code;
    logic [7:0] cancel_code;
  } hdr_codes_t;

  typedef struct packed {
    event_t     event_res;
    logic [7:0] display_byte;
    logic       command_start;
    logic       command_end;
    logic [7:0] sleep_loops;
    logic [7:0] sleep_exponent;
    logic       nak_code;
    logic [7:0] last_good_sequence;
  } result_t;

endpackage

// ===== rtl/sequenced_display_packet_receiver.sv =====
`timescale 1ns / 1ps

// Display packet receiver.
// Input stream: one word per received radio byte. tuser = 0 opens a new
// session (tdata ignored), tuser = 1 delivers tdata[7:0] with its receiver
// overrun flag in tdata[8]. Each word yields zero or one result word.
// Output stream: tuser carries the event (display byte, command end, ACK,
// cancel, NAK); tlast marks the end of a display command; tdata carries the
// byte, command start flag, sleep parameters, NAK code and last good sequence.
// A result goes into the single output register and is shown in the cycle after
// its input word is accepted; one word per cycle is taken while s_axis_tready is
// high. The header/sequence state advances in the same cycle as the accept.
// When the output is stalled the input is still taken as long as the output
// register is empty or being emptied in that cycle; otherwise tready drops.
// Reset (synchronous, rst high) restores the header codes to 2, 3 and 24, closes the
// session and empties the output register. Header codes are written through the APB
// port at byte addresses 0, 4 and 8; the user must write only while idle (not enforced).
module sequenced_display_packet_receiver (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [15:0]                  s_axis_tdata,  // rx_byte[7:0], overrun[8], zero[15:9]
  input  logic                         s_axis_tuser,  // cmd
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // display_byte[7:0], command_start[8], sleep_loops[16:9], sleep_exponent[24:17],
  // nak_code[25], last_good_sequence[33:26], zero[39:34]
  output logic [39:0]                  m_axis_tdata,
  output logic [2:0]                   m_axis_tuser,  // event_res
  output logic                         m_axis_tlast,  // command_end
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sdpr_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  sdpr_pkg::hdr_codes_t codes;
  sdpr_pkg::result_t    res;
  sdpr_pkg::result_t    out_res;
  logic                 res_valid;
  logic                 accept;
  logic                 can_load;

  assign pready        = 1'b1;
  assign s_axis_tready = can_load;
  assign accept        = s_axis_tvalid && can_load;

  sdpr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .codes   (codes)
  );

  sdpr_deframer u_deframer (
    .clk       (clk),
    .rst       (rst),
    .codes     (codes),
    .accept    (accept),
    .cmd       (s_axis_tuser),
    .rx_byte   (s_axis_tdata[7:0]),
    .overrun   (s_axis_tdata[8]),
    .res_valid (res_valid),
    .res       (res)
  );

  sdpr_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .load_res  (res),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_res   (out_res),
    .can_load  (can_load)
  );

  assign m_axis_tuser = out_res.event_res;
  assign m_axis_tlast = out_res.command_end;
  assign m_axis_tdata = {6'd0,
                         out_res.last_good_sequence,
                         out_res.nak_code,
                         out_res.sleep_exponent,
                         out_res.sleep_loops,
                         out_res.command_start,
                         out_res.display_byte};

endmodule

// ===== rtl/sdpr_cfg.sv =====
`timescale 1ns / 1ps

module sdpr_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sdpr_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output sdpr_pkg::hdr_codes_t         codes
);

  logic       wr_en;
  logic [1:0] reg_sel;

  assign reg_sel = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      codes.normal_code <= sdpr_pkg::NORMAL_HDR_RESET;
      codes.last_code   <= sdpr_pkg::LAST_HDR_RESET;
      codes.cancel_code <= sdpr_pkg::CANCEL_HDR_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        sdpr_pkg::REG_NORMAL_HDR: codes.normal_code <= pwdata[7:0];
        sdpr_pkg::REG_LAST_HDR:   codes.last_code   <= pwdata[7:0];
        sdpr_pkg::REG_CANCEL_HDR: codes.cancel_code <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      sdpr_pkg::REG_NORMAL_HDR: prdata = {24'd0, codes.normal_code};
      sdpr_pkg::REG_LAST_HDR:   prdata = {24'd0, codes.last_code};
      sdpr_pkg::REG_CANCEL_HDR: prdata = {24'd0, codes.cancel_code};
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/sdpr_deframer.sv =====
`timescale 1ns / 1ps

module sdpr_deframer (
  input  logic                 clk,
  input  logic                 rst,
  input  sdpr_pkg::hdr_codes_t codes,
  input  logic                 accept,
  input  logic                 cmd,
  input  logic [7:0]           rx_byte,
  input  logic                 overrun,
  output logic                 res_valid,
  output sdpr_pkg::result_t    res
);

  sdpr_pkg::phase_t phase, phase_next;
  sdpr_pkg::kind_t  kind, kind_next;
  logic [7:0] expected_seq, expected_seq_next;
  logic       accepting, accepting_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic       first_pending, first_pending_next;
  logic [7:0] held_loops, held_loops_next;

  sdpr_pkg::phase_t after_payload;
  logic             last_byte;
  logic             is_cancel;
  logic             is_last;
  logic             is_normal;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= sdpr_pkg::PH_IDLE;
      kind          <= sdpr_pkg::KIND_NORMAL;
      expected_seq  <= 8'd0;
      accepting     <= 1'b0;
      bytes_left    <= 8'd0;
      first_pending <= 1'b0;
      held_loops    <= 8'd0;
    end else begin
      phase         <= phase_next;
      kind          <= kind_next;
      expected_seq  <= expected_seq_next;
      accepting     <= accepting_next;
      bytes_left    <= bytes_left_next;
      first_pending <= first_pending_next;
      held_loops    <= held_loops_next;
    end
  end

  assign after_payload = (kind == sdpr_pkg::KIND_LAST) ? sdpr_pkg::PH_SLEEP1
                                                       : sdpr_pkg::PH_HEADER;
  assign last_byte = (bytes_left <= 8'd1);
  assign is_cancel = (rx_byte == codes.cancel_code);
  assign is_last   = (rx_byte == codes.last_code);
  assign is_normal = (rx_byte == codes.normal_code);

  always_comb begin
    phase_next         = phase;
    kind_next          = kind;
    expected_seq_next  = expected_seq;
    accepting_next     = accepting;
    bytes_left_next    = bytes_left;
    first_pending_next = first_pending;
    held_loops_next    = held_loops;
    res_valid          = 1'b0;
    res                = '0;

    if (accept) begin
      if (cmd == sdpr_pkg::CMD_START) begin
        phase_next         = sdpr_pkg::PH_HEADER;
        kind_next          = sdpr_pkg::KIND_NORMAL;
        expected_seq_next  = 8'd0;
        accepting_next     = 1'b0;
        bytes_left_next    = 8'd0;
        first_pending_next = 1'b0;
      end else begin
        unique case (phase)
          sdpr_pkg::PH_IDLE: ;
          sdpr_pkg::PH_HEADER: begin
            // Cancel wins over last, and last over normal, when codes coincide.
            if (is_cancel) begin
              kind_next  = sdpr_pkg::KIND_CANCEL;
              phase_next = sdpr_pkg::PH_SLEEP1;
            end else if (is_last || is_normal) begin
              if (overrun) begin
                phase_next             = sdpr_pkg::PH_IDLE;
                res_valid              = 1'b1;
                res.event_res          = sdpr_pkg::EV_NAK;
                res.nak_code           = sdpr_pkg::NAK_OVERRUN;
                res.last_good_sequence = expected_seq - 8'd1;
              end else begin
                kind_next  = is_last ? sdpr_pkg::KIND_LAST : sdpr_pkg::KIND_NORMAL;
                phase_next = sdpr_pkg::PH_SEQ;
              end
            end else begin
              phase_next             = sdpr_pkg::PH_IDLE;
              res_valid              = 1'b1;
              res.event_res          = sdpr_pkg::EV_NAK;
              res.nak_code           = sdpr_pkg::NAK_BAD_HEADER;
              res.last_good_sequence = expected_seq - 8'd1;
            end
          end
          sdpr_pkg::PH_SEQ: begin
            accepting_next = (rx_byte == expected_seq);
            if (rx_byte == expected_seq) begin
              expected_seq_next = expected_seq + 8'd1;
            end
            phase_next = sdpr_pkg::PH_LEN;
          end
          sdpr_pkg::PH_LEN: begin
            bytes_left_next = rx_byte;
            if (rx_byte == 8'd0) begin
              // An empty accepted command still reports its end.
              phase_next         = after_payload;
              first_pending_next = 1'b0;
              if (accepting) begin
                res_valid         = 1'b1;
                res.event_res     = sdpr_pkg::EV_CMD_END;
                res.command_start = 1'b1;
                res.command_end   = 1'b1;
              end
            end else begin
              first_pending_next = 1'b1;
              phase_next         = sdpr_pkg::PH_DATA;
            end
          end
          sdpr_pkg::PH_DATA: begin
            first_pending_next = 1'b0;
            if (last_byte) begin
              bytes_left_next = 8'd0;
              phase_next      = after_payload;
            end else begin
              bytes_left_next = bytes_left - 8'd1;
            end
            if (accepting) begin
              res_valid         = 1'b1;
              res.event_res     = sdpr_pkg::EV_DISPLAY;
              res.display_byte  = rx_byte;
              res.command_start = first_pending;
              res.command_end   = last_byte;
            end
          end
          sdpr_pkg::PH_SLEEP1: begin
            held_loops_next = rx_byte;
            phase_next      = sdpr_pkg::PH_SLEEP2;
          end
          sdpr_pkg::PH_SLEEP2: begin
            if (kind == sdpr_pkg::KIND_CANCEL) begin
              phase_next         = sdpr_pkg::PH_IDLE;
              res_valid          = 1'b1;
              res.event_res      = sdpr_pkg::EV_CANCEL;
              res.sleep_loops    = held_loops;
              res.sleep_exponent = rx_byte;
            end else if (accepting) begin
              phase_next         = sdpr_pkg::PH_IDLE;
              res_valid          = 1'b1;
              res.event_res      = sdpr_pkg::EV_ACK;
              res.sleep_loops    = held_loops;
              res.sleep_exponent = rx_byte;
            end else begin
              // A dropped last packet leaves the session open.
              phase_next = sdpr_pkg::PH_HEADER;
            end
          end
          default: ;
        endcase
      end
    end
  end

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    accept && cmd == sdpr_pkg::CMD_START
      |=> phase == sdpr_pkg::PH_HEADER && expected_seq == 8'd0 && !accepting)
    else $error("start word did not reopen the session");

  a_nak_closes: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.event_res == sdpr_pkg::EV_NAK |=> phase == sdpr_pkg::PH_IDLE)
    else $error("session still open after a NAK");

  a_data_count: assert property (@(posedge clk) disable iff (rst)
    phase == sdpr_pkg::PH_DATA |-> bytes_left != 8'd0)
    else $error("payload phase with no bytes left");

  a_ack_accepted: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.event_res == sdpr_pkg::EV_ACK
      |-> accepting && kind == sdpr_pkg::KIND_LAST)
    else $error("ACK for a packet that was not accepted");

endmodule

// ===== rtl/sdpr_out_reg.sv =====
`timescale 1ns / 1ps

module sdpr_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  sdpr_pkg::result_t load_res,
  input  logic              out_ready,
  output logic              out_valid,
  output sdpr_pkg::result_t out_res,
  output logic              can_load
);

  // The stage frees up in the same cycle its word is taken.
  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= load_res;
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import sdpr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic       cmd;
    logic [7:0] rx;
    logic       ovr;
    bit         typed;
    result_t    res;
  } rx_word_t;

  logic                clk;
  logic                rst;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata;
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [39:0]         m_axis_tdata;
  logic [2:0]          m_axis_tuser;
  logic                m_axis_tlast;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  // Directed expectation travelling with the word on the input side.
  bit                  drv_typed;
  result_t             drv_res;

  rx_word_t            rx_words[$];
  result_t             pending_events[$];
  int                  errors;
  int                  cycles;
  bit                  hold_req;

  // Header codes as programmed.
  logic [7:0]          normal_code;
  logic [7:0]          last_code;
  logic [7:0]          cancel_code;

  // Receiver state.
  phase_t              rcv_phase;
  logic [7:0]          rcv_expected_seq;
  logic                rcv_accepting;
  logic [7:0]          rcv_bytes_left;
  kind_t               rcv_kind;
  logic                rcv_first_pending;
  logic [7:0]          rcv_held_loops;

  sequenced_display_packet_receiver dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic result_t mk_res(event_t ev, logic [7:0] db, logic cs, logic ce,
                                     logic [7:0] sl, logic [7:0] se, logic nc,
                                     logic [7:0] lg);
    result_t r;
    r.event_res          = ev;
    r.display_byte       = db;
    r.command_start      = cs;
    r.command_end        = ce;
    r.sleep_loops        = sl;
    r.sleep_exponent     = se;
    r.nak_code           = nc;
    r.last_good_sequence = lg;
    return r;
  endfunction

  function automatic string fmt_res(result_t r);
    return $sformatf("ev=%0d db=%02h cs=%0b ce=%0b sl=%02h se=%02h nak=%0b lgs=%02h",
                     r.event_res, r.display_byte, r.command_start, r.command_end,
                     r.sleep_loops, r.sleep_exponent, r.nak_code, r.last_good_sequence);
  endfunction

  // Advances the receiver by one word; returns 1 when the word yields an event.
  function automatic bit predict_display_event(logic cmd, logic [7:0] b, logic ovr,
                                               output result_t r);
    bit is_last;
    logic start;
    r = mk_res(EV_DISPLAY, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00);
    if (cmd == CMD_START) begin
      rcv_phase         = PH_HEADER;
      rcv_expected_seq  = 8'h00;
      rcv_accepting     = 1'b0;
      rcv_bytes_left    = 8'h00;
      rcv_kind          = KIND_NORMAL;
      rcv_first_pending = 1'b0;
      return 1'b0;
    end
    case (rcv_phase)
      PH_HEADER: begin
        if (b == cancel_code) begin
          rcv_kind  = KIND_CANCEL;
          rcv_phase = PH_SLEEP1;
          return 1'b0;
        end
        if (b == last_code || b == normal_code) begin
          if (ovr) begin
            rcv_phase = PH_IDLE;
            r.event_res          = EV_NAK;
            r.nak_code           = NAK_OVERRUN;
            r.last_good_sequence = rcv_expected_seq - 8'd1;
            return 1'b1;
          end
          rcv_kind  = (b == last_code) ? KIND_LAST : KIND_NORMAL;
          rcv_phase = PH_SEQ;
          return 1'b0;
        end
        rcv_phase = PH_IDLE;
        r.event_res          = EV_NAK;
        r.nak_code           = NAK_BAD_HEADER;
        r.last_good_sequence = rcv_expected_seq - 8'd1;
        return 1'b1;
      end
      PH_SEQ: begin
        rcv_accepting = (b == rcv_expected_seq);
        if (rcv_accepting) rcv_expected_seq = rcv_expected_seq + 8'd1;
        rcv_phase = PH_LEN;
        return 1'b0;
      end
      PH_LEN: begin
        rcv_bytes_left    = b;
        rcv_first_pending = 1'b1;
        if (b == 8'h00) begin
          rcv_phase         = (rcv_kind == KIND_LAST) ? PH_SLEEP1 : PH_HEADER;
          rcv_first_pending = 1'b0;
          if (rcv_accepting) begin
            r.event_res     = EV_CMD_END;
            r.command_start = 1'b1;
            r.command_end   = 1'b1;
            return 1'b1;
          end
          return 1'b0;
        end
        rcv_phase = PH_DATA;
        return 1'b0;
      end
      PH_DATA: begin
        start             = rcv_first_pending;
        is_last           = (rcv_bytes_left <= 8'd1);
        rcv_first_pending = 1'b0;
        rcv_bytes_left    = rcv_bytes_left - 8'd1;
        if (is_last) begin
          rcv_bytes_left = 8'h00;
          rcv_phase      = (rcv_kind == KIND_LAST) ? PH_SLEEP1 : PH_HEADER;
        end
        if (rcv_accepting) begin
          r.event_res     = EV_DISPLAY;
          r.display_byte  = b;
          r.command_start = start;
          r.command_end   = is_last;
          return 1'b1;
        end
        return 1'b0;
      end
      PH_SLEEP1: begin
        rcv_held_loops = b;
        rcv_phase      = PH_SLEEP2;
        return 1'b0;
      end
      PH_SLEEP2: begin
        if (rcv_kind == KIND_CANCEL || rcv_accepting) begin
          r.event_res      = (rcv_kind == KIND_CANCEL) ? EV_CANCEL : EV_ACK;
          r.sleep_loops    = rcv_held_loops;
          r.sleep_exponent = b;
          rcv_phase        = PH_IDLE;
          return 1'b1;
        end
        rcv_phase = PH_HEADER;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Idle cycles before the next word, with occasional stretches of back-to-back words.
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      burst = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  task automatic add_word(logic cmd, logic [7:0] rx, logic ovr);
    rx_word_t w;
    w.cmd   = cmd;
    w.rx    = rx;
    w.ovr   = ovr;
    w.typed = 1'b0;
    w.res   = mk_res(EV_DISPLAY, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00);
    rx_words.push_back(w);
  endtask

  task automatic add_typed(logic cmd, logic [7:0] rx, logic ovr, result_t res);
    add_word(cmd, rx, ovr);
    rx_words[rx_words.size() - 1].typed = 1'b1;
    rx_words[rx_words.size() - 1].res   = res;
  endtask

  task automatic apb_write(logic [1:0] idx, logic [7:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, val};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_NORMAL_HDR: normal_code = val;
      REG_LAST_HDR:   last_code   = val;
      REG_CANCEL_HDR: cancel_code = val;
      default: ;
    endcase
  endtask

  task automatic set_codes(logic [7:0] nrm, logic [7:0] lst, logic [7:0] cnc);
    apb_write(REG_NORMAL_HDR, nrm);
    apb_write(REG_LAST_HDR, lst);
    apb_write(REG_CANCEL_HDR, cnc);
  endtask

  // Mostly well-formed sessions with random content, plus broken ones and noise.
  task automatic gen_sessions(int target);
    int         start_size;
    int         packets;
    int         sel;
    int         len;
    bit         is_last;
    bit         done;
    logic [7:0] gen_seq;
    logic [7:0] seq;
    logic [7:0] b;
    start_size = rx_words.size();
    while (rx_words.size() - start_size < target) begin
      add_word(CMD_START, 8'($urandom), 1'($urandom));
      gen_seq = 8'h00;
      packets = $urandom_range(1, 6);
      done    = 1'b0;
      for (int k = 0; k < packets && !done; k++) begin
        sel = $urandom_range(0, 99);
        if (sel < 4) begin
          do b = 8'($urandom);
          while (b == normal_code || b == last_code || b == cancel_code);
          add_word(CMD_BYTE, b, 1'($urandom));
          done = 1'b1;
        end else if (sel < 7) begin
          add_word(CMD_BYTE, ($urandom_range(0, 1) != 0) ? normal_code : last_code, 1'b1);
          done = 1'b1;
        end else if (sel < 12) begin
          add_word(CMD_BYTE, cancel_code, 1'($urandom));
          add_word(CMD_BYTE, 8'($urandom), 1'($urandom));
          add_word(CMD_BYTE, 8'($urandom), 1'($urandom));
          done = 1'b1;
        end else if (sel < 15) begin
          add_word(CMD_START, 8'($urandom), 1'($urandom));
          gen_seq = 8'h00;
        end else begin
          is_last = (k == packets - 1) || (sel < 25);
          add_word(CMD_BYTE, is_last ? last_code : normal_code, 1'b0);
          seq = ($urandom_range(0, 9) == 0) ? 8'($urandom) : gen_seq;
          if (seq == gen_seq) gen_seq = gen_seq + 8'd1;
          else if (is_last) packets++;
          add_word(CMD_BYTE, seq, ($urandom_range(0, 7) == 0));
          len = ($urandom_range(0, 39) == 0) ? $urandom_range(128, 255) : $urandom_range(0, 8);
          add_word(CMD_BYTE, 8'(len), ($urandom_range(0, 7) == 0));
          for (int i = 0; i < len; i++)
            add_word(CMD_BYTE, 8'($urandom), ($urandom_range(0, 7) == 0));
          if (is_last) begin
            add_word(CMD_BYTE, 8'($urandom), ($urandom_range(0, 7) == 0));
            add_word(CMD_BYTE, 8'($urandom), ($urandom_range(0, 7) == 0));
            if (seq == gen_seq - 8'd1) done = 1'b1;
          end
        end
      end
      // Stray words between sessions, mostly ignored by the block.
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 3)) add_word(CMD_BYTE, 8'($urandom), 1'($urandom));
    end
  endtask

  task automatic send_words();
    rx_word_t w;
    int       gap;
    int       burst;
    burst = 0;
    while (rx_words.size() != 0) begin
      w   = rx_words.pop_front();
      gap = draw_gap(burst);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= {7'h00, w.ovr, w.rx};
      s_axis_tuser  <= w.cmd;
      drv_typed     <= w.typed;
      drv_res       <= w.res;
      do @(posedge clk); while (!s_axis_tready);
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_events.size() != 0) @(posedge clk);
    repeat (5) @(negedge clk);
  endtask

  // Checking of both streams at the rising edge.
  always @(posedge clk) begin
    result_t pred;
    result_t got;
    result_t want;
    bit      has;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      has = predict_display_event(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[8], pred);
      if (drv_typed) pending_events.push_back(drv_res);
      else if (has) pending_events.push_back(pred);
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = mk_res(event_t'(m_axis_tuser), m_axis_tdata[7:0], m_axis_tdata[8], m_axis_tlast,
                   m_axis_tdata[16:9], m_axis_tdata[24:17], m_axis_tdata[25],
                   m_axis_tdata[33:26]);
      if (pending_events.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) $display("unexpected result word: %s", fmt_res(got));
      end else begin
        want = pending_events.pop_front();
        if (got.event_res !== want.event_res || got.display_byte !== want.display_byte ||
            got.command_start !== want.command_start ||
            got.command_end !== want.command_end || got.sleep_loops !== want.sleep_loops ||
            got.sleep_exponent !== want.sleep_exponent || got.nak_code !== want.nak_code ||
            got.last_good_sequence !== want.last_good_sequence) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("result mismatch: expected %s, got %s", fmt_res(want), fmt_res(got));
        end
      end
    end
  end

  // Output side: random stalls, and one long hold-off on request.
  initial begin
    int stall;
    int burst;
    burst = 0;
    m_axis_tready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      stall = draw_gap(burst);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    errors        = 0;
    cycles        = 0;
    hold_req      = 1'b0;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 16'h0000;
    s_axis_tuser  = CMD_START;
    drv_typed     = 1'b0;
    drv_res       = mk_res(EV_DISPLAY, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00);
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = 32'h0;
    normal_code   = NORMAL_HDR_RESET;
    last_code     = LAST_HDR_RESET;
    cancel_code   = CANCEL_HDR_RESET;
    rcv_phase         = PH_IDLE;
    rcv_expected_seq  = 8'h00;
    rcv_accepting     = 1'b0;
    rcv_bytes_left    = 8'h00;
    rcv_kind          = KIND_NORMAL;
    rcv_first_pending = 1'b0;
    rcv_held_loops    = 8'h00;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Directed words under the reset header codes.
    add_word(CMD_BYTE, 8'h02, 1'b0);             // byte before any session
    add_word(CMD_START, 8'h00, 1'b0);
    add_typed(CMD_BYTE, 8'hFF, 1'b0,
              mk_res(EV_NAK, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00, NAK_BAD_HEADER, 8'hFF));
    add_word(CMD_START, 8'hFF, 1'b1);
    add_word(CMD_BYTE, 8'h02, 1'b0);
    add_word(CMD_BYTE, 8'h00, 1'b0);
    add_typed(CMD_BYTE, 8'h00, 1'b0,
              mk_res(EV_CMD_END, 8'h00, 1'b1, 1'b1, 8'h00, 8'h00, 1'b0, 8'h00));
    add_word(CMD_BYTE, 8'h03, 1'b0);
    add_word(CMD_BYTE, 8'h01, 1'b0);
    add_word(CMD_BYTE, 8'h02, 1'b0);
    add_word(CMD_BYTE, 8'hFF, 1'b0);
    add_word(CMD_BYTE, 8'h00, 1'b1);
    add_word(CMD_BYTE, 8'hFF, 1'b0);
    add_typed(CMD_BYTE, 8'h80, 1'b0,
              mk_res(EV_ACK, 8'h00, 1'b0, 1'b0, 8'hFF, 8'h80, 1'b0, 8'h00));
    add_word(CMD_START, 8'h00, 1'b0);
    add_typed(CMD_BYTE, 8'h02, 1'b1,
              mk_res(EV_NAK, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00, NAK_OVERRUN, 8'hFF));
    add_word(CMD_START, 8'h00, 1'b0);
    add_word(CMD_BYTE, 8'h02, 1'b0);
    add_word(CMD_BYTE, 8'h05, 1'b0);             // out of order, payload dropped
    add_word(CMD_BYTE, 8'h01, 1'b0);
    add_word(CMD_BYTE, 8'hAA, 1'b1);
    add_word(CMD_BYTE, 8'h18, 1'b1);             // cancel header ignores overrun
    add_word(CMD_BYTE, 8'h00, 1'b0);
    add_typed(CMD_BYTE, 8'hFF, 1'b0,
              mk_res(EV_CANCEL, 8'h00, 1'b0, 1'b0, 8'h00, 8'hFF, 1'b0, 8'h00));
    add_word(CMD_START, 8'h00, 1'b0);
    add_word(CMD_BYTE, 8'h02, 1'b0);
    add_word(CMD_START, 8'h00, 1'b0);            // restart in mid-packet
    send_words();
    drain();
    gen_sessions(165);
    send_words();
    drain();

    set_codes(8'h00, 8'hFF, 8'h80);
    gen_sessions(165);
    hold_req = 1'b1;
    send_words();
    drain();

    set_codes(8'hFF, 8'h00, 8'h7F);
    gen_sessions(165);
    send_words();
    drain();

    // Normal and last share a code, so last takes precedence.
    set_codes(8'h40, 8'h40, 8'h00);
    gen_sessions(165);
    send_words();
    drain();

    // All three codes equal: every header is a cancel.
    set_codes(8'hFF, 8'hFF, 8'hFF);
    gen_sessions(100);
    send_words();
    drain();

    set_codes(8'($urandom), 8'($urandom), 8'($urandom));
    gen_sessions(165);
    send_words();
    drain();

    repeat (20) @(posedge clk);
    errors += pending_events.size();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
